// File: rtl/core/utfv_pkg.sv
// shared types, constants and helper functions for the utf-8 filename validator
`default_nettype none

package utfv_pkg;

   // name length counter
   localparam int unsigned COUNT_W   = 12;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // suffix window
   localparam int unsigned SUFFIX_MAX_BYTES = 8;
   localparam int unsigned SUFFIX_LEN_W     = $clog2(SUFFIX_MAX_BYTES + 1);
   localparam int unsigned SUFFIX_IDX_W     = (SUFFIX_MAX_BYTES > 1) ?
                                              $clog2(SUFFIX_MAX_BYTES) : 1;
   localparam int unsigned PATTERN_W        = 8 * SUFFIX_MAX_BYTES;

   // register file
   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam logic [1:0]  REG_MAX_NAME_BYTES = 2'd0;
   localparam logic [1:0]  REG_SUFFIX_PATTERN = 2'd1;
   localparam logic [1:0]  REG_SUFFIX_LENGTH  = 2'd2;

   localparam logic [COUNT_W-1:0]      MAX_NAME_RESET   = 12'd255;
   localparam logic [SUFFIX_LEN_W-1:0] SUFFIX_LEN_RESET = SUFFIX_LEN_W'(1);

   // characters
   localparam logic [7:0] CHAR_DOT   = 8'h2e;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DEL   = 8'h7f;

   // code point limits
   localparam int unsigned CP_W = 21;
   localparam logic [CP_W-1:0] CP_MAX       = 21'h10ffff;
   localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h00d800;
   localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h00dfff;
   localparam logic [CP_W-1:0] CP_C1_LO     = 21'h000080;
   localparam logic [CP_W-1:0] CP_C1_HI     = 21'h00009f;
   localparam logic [CP_W-1:0] CP_MIN_TWO   = 21'h000080;
   localparam logic [CP_W-1:0] CP_MIN_THREE = 21'h000800;
   localparam logic [CP_W-1:0] CP_MIN_FOUR  = 21'h010000;

   // decoder status toward the top level
   typedef struct packed {
      logic bad;         // this byte breaks the name
      logic incomplete;  // a sequence is still open after this byte
   } utfv_dec_status_type;

   function automatic logic forbidden_byte(input logic [7:0] b);
      return (b < CHAR_SPACE) || (b == CHAR_DEL) || (b == 8'h2f) || (b == 8'h5c) ||
             (b == 8'h3a) || (b == 8'h3c) || (b == 8'h3e) || (b == 8'h22) ||
             (b == 8'h7c) || (b == 8'h3f) || (b == 8'h2a);
   endfunction

   function automatic logic [CP_W-1:0] class_minimum(input logic [1:0] cls);
      logic [CP_W-1:0] m;
      case (cls)
         2'd1:    m = CP_MIN_TWO;
         2'd2:    m = CP_MIN_THREE;
         2'd3:    m = CP_MIN_FOUR;
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/utf8_filename_validator.sv
// top level of the utf-8 filename validator: handshakes, registers, name checks
`default_nettype none

// channel   direction  ports                                   meaning
// request   in         req_valid/req_ready, name_byte, last    one filename byte
// response  out        rsp_valid/rsp_ready, name_ok, length    verdict on the last byte
// csr       in/out     csr_psel/penable/pwrite/paddr/pwdata    max length, suffix, suffix len
//
// one byte per cycle unless a verdict stalls: each request is held in the input register,
// then the decoder, window compare and length check update all per-name state in one pass
// a verdict enters the response register when its last byte leaves the input register
// the input register only holds when a verdict waits there and the response register is full
// reset is synchronous; it clears the name state and loads the register defaults
// csr registers lie at byte addresses 0, 8 and 16; reads return the stored value

module utf8_filename_validator import utfv_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [7:0]            req_name_byte,
   input  wire logic                  req_last_byte,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_name_ok,
   output logic [COUNT_W-1:0]         rsp_name_length,
   // configuration port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   // configuration registers
   logic [COUNT_W-1:0]      max_name_ff;
   logic [PATTERN_W-1:0]    pattern_ff;
   logic [SUFFIX_LEN_W-1:0] suffix_len_ff;
   logic [1:0]              reg_sel;
   logic                    csr_write;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       req_take;
   logic       step;

   // per-name state kept here
   logic [COUNT_W-1:0] byte_count_ff;
   logic [COUNT_W-1:0] count_new;
   logic               failed_ff, failed_new;
   logic               dots_ff, dots_new;
   logic               len_fail;
   logic               cnt_sat;

   // results of the sub-blocks
   utfv_dec_status_type dec_status;
   logic                suffix_seen;
   logic                verdict;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff;
   logic [COUNT_W-1:0] rsp_len_ff;

   // ---------------------------------------------------------------- csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[4:3];

   always_comb begin
      unique case (reg_sel)
         REG_MAX_NAME_BYTES: csr_prdata = CSR_DATA_W'(max_name_ff);
         REG_SUFFIX_PATTERN: csr_prdata = CSR_DATA_W'(pattern_ff);
         REG_SUFFIX_LENGTH:  csr_prdata = CSR_DATA_W'(suffix_len_ff);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_name_ff   <= MAX_NAME_RESET;
         pattern_ff    <= '0;
         suffix_len_ff <= SUFFIX_LEN_RESET;
      end else if (csr_write) begin
         unique case (reg_sel)
            REG_MAX_NAME_BYTES: max_name_ff   <= csr_pwdata[COUNT_W-1:0];
            REG_SUFFIX_PATTERN: pattern_ff    <= csr_pwdata[PATTERN_W-1:0];
            REG_SUFFIX_LENGTH:  suffix_len_ff <= csr_pwdata[SUFFIX_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- flow control
   // a byte is processed unless it carries a verdict and the response slot is full
   assign step        = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || step;
   assign req_take    = req_valid && req_ready;
   assign in_valid_in = req_take || (in_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_name_byte;
         in_last_ff <= req_last_byte;
      end
   end

   // ---------------------------------------------------------------- name checks
   utfv_utf8 u_utf8 (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .last      (in_last_ff),
      .data_byte (in_byte_ff),
      .status    (dec_status)
   );

   utfv_suffix u_suffix (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .last      (in_last_ff),
      .data_byte (in_byte_ff),
      .count_new (count_new),
      .pattern   (pattern_ff),
      .length    (suffix_len_ff),
      .seen      (suffix_seen)
   );

   always_comb begin
      // saturating length; a saturated name is too long for any limit
      cnt_sat    = (byte_count_ff == COUNT_MAX);
      count_new  = cnt_sat ? byte_count_ff : byte_count_ff + COUNT_W'(1);
      len_fail   = cnt_sat || (count_new > max_name_ff);
      failed_new = failed_ff || len_fail || suffix_seen || dec_status.bad;
      dots_new   = dots_ff && (in_byte_ff == CHAR_DOT);
      // "." and "..", trailing dot or space, and a cut-off sequence all fail
      verdict    = !failed_new && !dec_status.incomplete &&
                   (in_byte_ff != CHAR_DOT) && (in_byte_ff != CHAR_SPACE) &&
                   !(dots_new && count_new <= COUNT_W'(2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         failed_ff     <= 1'b0;
         dots_ff       <= 1'b1;
      end else if (step) begin
         if (in_last_ff) begin
            byte_count_ff <= '0;
            failed_ff     <= 1'b0;
            dots_ff       <= 1'b1;
         end else begin
            byte_count_ff <= count_new;
            failed_ff     <= failed_new;
            dots_ff       <= dots_new;
         end
      end
   end

   // ---------------------------------------------------------------- response register
   always_comb begin
      if (step && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && in_last_ff) begin
         rsp_ok_ff  <= verdict;
         rsp_len_ff <= count_new;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_name_ok     = rsp_ok_ff;
   assign rsp_name_length = rsp_len_ff;

`ifndef SYNTHESIS
   // a verdict leaves the per-name state at its start values
   a_clear_after_verdict: assert property (@(posedge clock) disable iff (reset)
      (step && in_last_ff) |=> (byte_count_ff == '0 && !failed_ff && dots_ff))
      else $error("name state not cleared after verdict");

   // the input register holds only behind a full response slot
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !step) |-> (in_last_ff && rsp_valid_ff && !rsp_ready))
      else $error("input register stalled without a full response slot");

   // an accepted name counts at least one byte
   a_ok_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ok_ff) |-> (rsp_len_ff != '0))
      else $error("accepted name with zero length");

   // the response slot is loaded only when it is free or being drained
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (step && in_last_ff) |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before it was taken");
`endif

endmodule

`default_nettype wire

// File: rtl/core/utfv_utf8.sv
// utf-8 sequence decoder with its per-name state
`default_nettype none

module utfv_utf8 import utfv_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic                last,
   input  wire logic [7:0]          data_byte,
   output utfv_dec_status_type      status
);

   logic [1:0]      pend_ff, pend_in;
   logic [CP_W-1:0] cp_ff, cp_in;
   logic [1:0]      cls_ff, cls_in;
   logic            bad;

   always_comb begin
      pend_in = pend_ff;
      cp_in   = cp_ff;
      cls_in  = cls_ff;
      bad     = 1'b0;
      if (pend_ff == 2'd0) begin
         bad = forbidden_byte(data_byte);
         if (data_byte >= 8'hc2 && data_byte <= 8'hdf) begin
            pend_in = 2'd1;
            cp_in   = CP_W'(data_byte[4:0]);
            cls_in  = 2'd1;
         end else if (data_byte >= 8'he0 && data_byte <= 8'hef) begin
            pend_in = 2'd2;
            cp_in   = CP_W'(data_byte[3:0]);
            cls_in  = 2'd2;
         end else if (data_byte >= 8'hf0 && data_byte <= 8'hf4) begin
            pend_in = 2'd3;
            cp_in   = CP_W'(data_byte[2:0]);
            cls_in  = 2'd3;
         end else if (data_byte[7]) begin
            bad = 1'b1;
         end
      end else begin
         if (data_byte[7:6] != 2'b10) begin
            bad = 1'b1;
         end
         cp_in   = {cp_ff[CP_W-7:0], data_byte[5:0]};
         pend_in = pend_ff - 2'd1;
         // sequence closes: overlong, range, surrogate and c1 checks
         if (pend_in == 2'd0) begin
            if (cp_in < class_minimum(cls_ff) || cp_in > CP_MAX ||
                (cp_in >= CP_SURR_LO && cp_in <= CP_SURR_HI) ||
                (cp_in >= CP_C1_LO && cp_in <= CP_C1_HI)) begin
               bad = 1'b1;
            end
         end
      end
      status.bad        = bad;
      status.incomplete = (pend_in != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         cp_ff   <= '0;
         cls_ff  <= '0;
      end else if (step) begin
         if (last) begin
            pend_ff <= '0;
            cp_ff   <= '0;
            cls_ff  <= '0;
         end else begin
            pend_ff <= pend_in;
            cp_ff   <= cp_in;
            cls_ff  <= cls_in;
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/utfv_suffix.sv
// window of recent bytes and forbidden suffix match
`default_nettype none

module utfv_suffix import utfv_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire logic                    last,
   input  wire logic [7:0]              data_byte,
   input  wire logic [COUNT_W-1:0]      count_new,
   input  wire logic [PATTERN_W-1:0]    pattern,
   input  wire logic [SUFFIX_LEN_W-1:0] length,
   output logic                         seen
);

   logic [7:0]              window_ff  [SUFFIX_MAX_BYTES];
   logic [7:0]              window_new [SUFFIX_MAX_BYTES];
   logic [SUFFIX_LEN_W-1:0] len_eff;
   logic [SUFFIX_IDX_W-1:0] idx;

   // entry 0 holds the newest byte
   always_comb begin
      window_new[0] = data_byte;
      for (int i = 1; i < SUFFIX_MAX_BYTES; i++) begin
         window_new[i] = window_ff[i-1];
      end
   end

   always_comb begin
      len_eff = (length > SUFFIX_LEN_W'(SUFFIX_MAX_BYTES)) ?
                SUFFIX_LEN_W'(SUFFIX_MAX_BYTES) : length;
      seen = 1'b1;
      idx  = '0;
      for (int k = 0; k < SUFFIX_MAX_BYTES; k++) begin
         idx = SUFFIX_IDX_W'(len_eff - SUFFIX_LEN_W'(k) - SUFFIX_LEN_W'(1));
         if (SUFFIX_LEN_W'(k) < len_eff && window_new[idx] != pattern[8*k +: 8]) begin
            seen = 1'b0;
         end
      end
      // empty suffix is found everywhere; a short name cannot hold it
      if (len_eff == '0) begin
         seen = 1'b1;
      end else if (count_new < COUNT_W'(len_eff)) begin
         seen = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SUFFIX_MAX_BYTES; i++) begin
            window_ff[i] <= '0;
         end
      end else if (step) begin
         for (int i = 0; i < SUFFIX_MAX_BYTES; i++) begin
            window_ff[i] <= last ? 8'h00 : window_new[i];
         end
      end
   end

endmodule

`default_nettype wire
